// ===== rtl/tamch_pkg.sv =====
// ----------------------------------------------------------------------------
// tamch_pkg: shared definitions of the three-axis motion command handler
// Command, error, action and register codes, the Y turn constants and the
// byte-folding helper that both checksums use.
// ----------------------------------------------------------------------------
package tamch_pkg;

  // Command bytes.
  localparam logic [7:0] OPC_MOVE_X    = 8'h01;
  localparam logic [7:0] OPC_MOVE_Y    = 8'h02;
  localparam logic [7:0] OPC_MOVE_Z    = 8'h03;
  localparam logic [7:0] OPC_HOME_X    = 8'h10;
  localparam logic [7:0] OPC_HOME_Y    = 8'h11;
  localparam logic [7:0] OPC_HOME_Z    = 8'h12;
  localparam logic [7:0] OPC_SET_SPEED = 8'h20;
  localparam logic [7:0] OPC_STATUS    = 8'h30;
  localparam logic [7:0] OPC_HALT      = 8'h40;
  localparam logic [7:0] OPC_TEMP      = 8'h50;
  localparam logic [7:0] OPC_FAN_START = 8'h51;
  localparam logic [7:0] OPC_FAN_HALT  = 8'h52;
  localparam logic [7:0] OPC_FAN_THR   = 8'h53;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CHECKSUM = 3'd1;
  localparam logic [2:0] ERR_COMMAND  = 3'd2;
  localparam logic [2:0] ERR_RANGE    = 3'd3;
  localparam logic [2:0] ERR_THERMAL  = 3'd4;

  // Action codes.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_MOVE     = 3'd1;
  localparam logic [2:0] ACT_HOME     = 3'd2;
  localparam logic [2:0] ACT_STOP_ALL = 3'd3;
  localparam logic [2:0] ACT_FAN_ON   = 3'd4;
  localparam logic [2:0] ACT_FAN_OFF  = 3'd5;
  localparam logic [2:0] ACT_FAN_THR  = 3'd6;

  // Axis indexes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_STOP_LIMIT = 2'd0;
  localparam logic [1:0] REG_X_MAX      = 2'd1;
  localparam logic [1:0] REG_Z_MAX      = 2'd2;

  // Reset values.
  localparam logic [15:0] STOP_LIMIT_RESET = 16'd8000;
  localparam logic [30:0] X_MAX_RESET      = 31'd200000;
  localparam logic [30:0] Z_MAX_RESET      = 31'd120000;
  localparam logic [31:0] X_SPEED_RESET    = 32'd2000;
  localparam logic [31:0] Y_SPEED_RESET    = 32'd1500;
  localparam logic [31:0] Z_SPEED_RESET    = 32'd1200;

  // Steps in one full turn of the Y axis (1 to 65535).
  localparam int unsigned Y_STEPS_PER_TURN = 6400;

  // Number of trailing zero bits of a nonzero constant.
  function automatic int unsigned trailing_zeros(input int unsigned d);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      if (((d >> n) & 1) == 0) n = n + 1;
    end
    return n;
  endfunction

  // Inverse of an odd constant modulo 2^32 by Newton iteration.
  function automatic logic [31:0] odd_inverse(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  // A value is a whole number of turns when its low Y_TURN_SHIFT bits are zero
  // and the rest, times the inverse of the odd part, stays at or below the limit.
  localparam int unsigned Y_TURN_SHIFT    = trailing_zeros(Y_STEPS_PER_TURN);
  localparam logic [31:0] Y_TURN_ODD      = 32'(Y_STEPS_PER_TURN >> Y_TURN_SHIFT);
  localparam logic [31:0] Y_TURN_INV      = odd_inverse(Y_TURN_ODD);
  localparam logic [31:0] Y_TURN_LIMIT    = 32'hFFFF_FFFF / Y_TURN_ODD;
  localparam logic [31:0] Y_TURN_LOW_MASK = (32'd1 << Y_TURN_SHIFT) - 32'd1;

  // XOR of the four bytes of a word.
  function automatic logic [7:0] xor_word(input logic [31:0] w);
    return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
  endfunction

endpackage

// ===== rtl/three_axis_motion_command_handler.sv =====
// ----------------------------------------------------------------------------
// three_axis_motion_command_handler: command decoder for a three-axis stage
// Checks command packets, keeps axis positions and speeds, and emits one
// response word with one motor or fan action per packet.
// ----------------------------------------------------------------------------
// The block accepts one command word per clock cycle while in_stall is low
// and returns exactly one response word for each, through the first-stage
// and response registers. The first stage checks the packet checksum and the
// temperature limit and updates the axis positions and speeds in the same
// cycle, so a following command sees the new state at once; the second stage
// derives the endstop flags from the positions (the Y test for a whole turn
// is one 32-bit multiply) and forms the response checksum. The endstop flags
// are kept as functions of the positions rather than as state of their own.
// Configuration registers sit on an APB-style port at byte addresses 0, 4
// and 8 and must only be written while no command is in flight.
module three_axis_motion_command_handler (
  input  logic               clk,
  input  logic               rst,
  // Command channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         command_code,
  input  logic [7:0]         axis_select,
  input  logic signed [31:0] value_arg,
  input  logic signed [31:0] speed_arg,
  input  logic [7:0]         packet_checksum,
  input  logic signed [15:0] temperature_cdeg,
  // Response channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status_flag,
  output logic [2:0]         error_code,
  output logic signed [31:0] x_position,
  output logic signed [31:0] y_position,
  output logic signed [31:0] z_position,
  output logic [2:0]         endstop_bits,
  output logic signed [15:0] reported_temp_cdeg,
  output logic [7:0]         response_checksum,
  output logic [2:0]         action_code,
  output logic [1:0]         action_axis,
  output logic signed [31:0] action_arg_a,
  output logic signed [31:0] action_arg_b,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic signed [15:0] emergency_stop_cdeg;
  logic [30:0]        x_max_steps;
  logic [30:0]        z_max_steps;

  // Axis state.
  logic [31:0] axis_position [3];
  logic [31:0] axis_position_next [3];
  logic [31:0] axis_speed [3];
  logic [31:0] axis_speed_next [3];

  // First stage: decoded result and position snapshot.
  logic        s1_valid;
  logic [2:0]  s1_err;
  logic [2:0]  s1_act;
  logic [1:0]  s1_axis;
  logic [31:0] s1_arg_a;
  logic [31:0] s1_arg_b;
  logic [31:0] s1_pos [3];
  logic [15:0] s1_temp;

  logic in_accept;
  logic out_load;

  // --------------------------------------------------------------------------
  // Handshake. The response register loads whenever it is empty or being
  // taken, and the first stage accepts whenever it is empty or moving on.
  // --------------------------------------------------------------------------
  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Configuration port. Writes land in the access phase; pready is tied high.
  // --------------------------------------------------------------------------
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      tamch_pkg::REG_STOP_LIMIT: prdata = {16'd0, emergency_stop_cdeg};
      tamch_pkg::REG_X_MAX:      prdata = {1'b0, x_max_steps};
      tamch_pkg::REG_Z_MAX:      prdata = {1'b0, z_max_steps};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emergency_stop_cdeg <= tamch_pkg::STOP_LIMIT_RESET;
      x_max_steps         <= tamch_pkg::X_MAX_RESET;
      z_max_steps         <= tamch_pkg::Z_MAX_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        tamch_pkg::REG_STOP_LIMIT: emergency_stop_cdeg <= pwdata[15:0];
        tamch_pkg::REG_X_MAX:      x_max_steps         <= pwdata[30:0];
        tamch_pkg::REG_Z_MAX:      z_max_steps         <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // First stage: packet check, thermal check and command execution.
  // --------------------------------------------------------------------------
  logic        csum_ok;
  logic        too_hot;
  logic        speed_pos;
  logic        is_move;
  logic        is_home;
  logic [1:0]  move_axis;
  logic [1:0]  home_axis;
  logic [31:0] move_pos;
  logic [32:0] move_target;
  logic [30:0] move_limit;
  logic        move_ok;
  logic [2:0]  err;
  logic [2:0]  act;
  logic [1:0]  act_axis;
  logic [31:0] arg_a;
  logic [31:0] arg_b;

  assign csum_ok = (command_code ^ axis_select ^ tamch_pkg::xor_word(value_arg)
                   ^ tamch_pkg::xor_word(speed_arg)) == packet_checksum;
  assign too_hot   = temperature_cdeg >= emergency_stop_cdeg;
  assign speed_pos = !speed_arg[31] && (speed_arg != 32'sd0);

  assign is_move   = (command_code >= tamch_pkg::OPC_MOVE_X) &&
                     (command_code <= tamch_pkg::OPC_MOVE_Z);
  assign is_home   = (command_code >= tamch_pkg::OPC_HOME_X) &&
                     (command_code <= tamch_pkg::OPC_HOME_Z);
  assign move_axis = command_code[1:0] - 2'd1;
  assign home_axis = command_code[1:0];

  // X and Z targets are checked as exact 33-bit sums against 0..max.
  assign move_pos    = axis_position[move_axis];
  assign move_target = {move_pos[31], move_pos} + {value_arg[31], value_arg};
  assign move_limit  = (move_axis == tamch_pkg::AXIS_X) ? x_max_steps : z_max_steps;
  assign move_ok     = (move_axis == tamch_pkg::AXIS_Y) ||
                       (!move_target[32] && (move_target[31:0] <= {1'b0, move_limit}));

  always_comb begin
    axis_position_next = axis_position;
    axis_speed_next    = axis_speed;
    err      = tamch_pkg::ERR_NONE;
    act      = tamch_pkg::ACT_NONE;
    act_axis = tamch_pkg::AXIS_X;
    arg_a    = 32'd0;
    arg_b    = 32'd0;
    priority if (!csum_ok) begin
      err = tamch_pkg::ERR_CHECKSUM;
    end else if (too_hot) begin
      err = tamch_pkg::ERR_THERMAL;
      act = tamch_pkg::ACT_STOP_ALL;
    end else if (is_move) begin
      if (!move_ok) begin
        err = tamch_pkg::ERR_RANGE;
      end else begin
        // A positive speed argument replaces the axis speed before the move.
        if (speed_pos) axis_speed_next[move_axis] = speed_arg;
        axis_position_next[move_axis] = move_pos + value_arg;
        act      = tamch_pkg::ACT_MOVE;
        act_axis = move_axis;
        arg_a    = value_arg;
        arg_b    = speed_pos ? speed_arg : axis_speed[move_axis];
      end
    end else if (is_home) begin
      axis_position_next[home_axis] = 32'd0;
      act      = tamch_pkg::ACT_HOME;
      act_axis = home_axis;
    end else if (command_code == tamch_pkg::OPC_SET_SPEED) begin
      if ((axis_select > 8'd2) || !speed_pos) begin
        err = tamch_pkg::ERR_COMMAND;
      end else begin
        axis_speed_next[axis_select[1:0]] = speed_arg;
      end
    end else if ((command_code == tamch_pkg::OPC_STATUS) ||
                 (command_code == tamch_pkg::OPC_TEMP)) begin
      act = tamch_pkg::ACT_NONE;
    end else if (command_code == tamch_pkg::OPC_HALT) begin
      act = tamch_pkg::ACT_STOP_ALL;
    end else if (command_code == tamch_pkg::OPC_FAN_START) begin
      act = tamch_pkg::ACT_FAN_ON;
    end else if (command_code == tamch_pkg::OPC_FAN_HALT) begin
      act = tamch_pkg::ACT_FAN_OFF;
    end else if (command_code == tamch_pkg::OPC_FAN_THR) begin
      // The on threshold must lie strictly above the off threshold.
      if (value_arg <= speed_arg) begin
        err = tamch_pkg::ERR_COMMAND;
      end else begin
        act   = tamch_pkg::ACT_FAN_THR;
        arg_a = value_arg;
        arg_b = speed_arg;
      end
    end else begin
      err = tamch_pkg::ERR_COMMAND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_position[0] <= 32'd0;
      axis_position[1] <= 32'd0;
      axis_position[2] <= 32'd0;
      axis_speed[0]    <= tamch_pkg::X_SPEED_RESET;
      axis_speed[1]    <= tamch_pkg::Y_SPEED_RESET;
      axis_speed[2]    <= tamch_pkg::Z_SPEED_RESET;
    end else if (in_accept) begin
      axis_position <= axis_position_next;
      axis_speed    <= axis_speed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_err   <= err;
      s1_act   <= act;
      s1_axis  <= act_axis;
      s1_arg_a <= arg_a;
      s1_arg_b <= arg_b;
      s1_pos   <= axis_position_next;
      s1_temp  <= temperature_cdeg;
    end
  end

  // --------------------------------------------------------------------------
  // Second stage: endstop flags and response checksum.
  // X and Z sit on their endstops at zero; Y does so at every whole turn,
  // tested on the magnitude with a multiply by the inverse of the odd part.
  // --------------------------------------------------------------------------
  logic [31:0] y_mag;
  logic [31:0] y_turn_prod;
  logic        y_whole_turn;
  logic [2:0]  mask;
  logic        status;
  logic [7:0]  rc;

  assign y_mag        = s1_pos[1][31] ? (32'd0 - s1_pos[1]) : s1_pos[1];
  assign y_turn_prod  = (y_mag >> tamch_pkg::Y_TURN_SHIFT) * tamch_pkg::Y_TURN_INV;
  assign y_whole_turn = ((y_mag & tamch_pkg::Y_TURN_LOW_MASK) == 32'd0) &&
                        (y_turn_prod <= tamch_pkg::Y_TURN_LIMIT);
  assign mask   = {s1_pos[2] == 32'd0, y_whole_turn, s1_pos[0] == 32'd0};
  assign status = s1_err != tamch_pkg::ERR_NONE;
  assign rc     = {7'd0, status} ^ {5'd0, s1_err} ^ tamch_pkg::xor_word(s1_pos[0])
                  ^ tamch_pkg::xor_word(s1_pos[1]) ^ tamch_pkg::xor_word(s1_pos[2])
                  ^ {5'd0, mask} ^ s1_temp[7:0] ^ s1_temp[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_flag        <= status;
      error_code         <= s1_err;
      x_position         <= s1_pos[0];
      y_position         <= s1_pos[1];
      z_position         <= s1_pos[2];
      endstop_bits       <= mask;
      reported_temp_cdeg <= s1_temp;
      response_checksum  <= rc;
      action_code        <= s1_act;
      action_axis        <= s1_axis;
      action_arg_a       <= s1_arg_a;
      action_arg_b       <= s1_arg_b;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The X and Z endstop flags follow their positions.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (endstop_bits[0] == (x_position == 32'sd0)) &&
                  (endstop_bits[2] == (z_position == 32'sd0)))
    else $error("endstop flag does not match X or Z position");

  // A move or home action is only reported for a command without error.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ((action_code == tamch_pkg::ACT_MOVE) ||
                  (action_code == tamch_pkg::ACT_HOME))
    |-> (error_code == tamch_pkg::ERR_NONE))
    else $error("motion action reported together with an error");

  // A packet with a bad checksum never causes an action.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == tamch_pkg::ERR_CHECKSUM)
    |-> (action_code == tamch_pkg::ACT_NONE))
    else $error("action issued for a packet with a bad checksum");

  // An accepted word always reaches the first stage.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted word lost before the first stage");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the three-axis motion command handler
// Drives command words with a valid/stall handshake, predicts every response
// word from its own model of the axis state, compares the responses field by
// field, and sweeps the APB registers through several settings.
// ----------------------------------------------------------------------------
module tb_top;

  // The slowest correct run is about 1150 words, each behind a sender gap
  // and a receiver stall, plus one hold-off and the drains between register
  // phases. This limit is several times that.
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_PRINTED = 40;

  // One command word as it goes into the block.
  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  axis;
    logic [31:0] val;
    logic [31:0] spd;
    logic [7:0]  csum;
    logic [15:0] temp;
  } cmd_word_t;

  // One response word as it comes out of the block.
  typedef struct packed {
    logic        status;
    logic [2:0]  err;
    logic [31:0] xpos;
    logic [31:0] ypos;
    logic [31:0] zpos;
    logic [2:0]  endstops;
    logic [15:0] temp;
    logic [7:0]  rsum;
    logic [2:0]  act;
    logic [1:0]  act_axis;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
  } resp_word_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         command_code;
  logic [7:0]         axis_select;
  logic signed [31:0] value_arg;
  logic signed [31:0] speed_arg;
  logic [7:0]         packet_checksum;
  logic signed [15:0] temperature_cdeg;
  logic               out_valid;
  logic               out_stall;
  logic               status_flag;
  logic [2:0]         error_code;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic signed [31:0] z_position;
  logic [2:0]         endstop_bits;
  logic signed [15:0] reported_temp_cdeg;
  logic [7:0]         response_checksum;
  logic [2:0]         action_code;
  logic [1:0]         action_axis;
  logic signed [31:0] action_arg_a;
  logic signed [31:0] action_arg_b;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  three_axis_motion_command_handler u_dut (.*);

  // Our own copy of the block's state and registers.
  logic [31:0] axis_pos [3];
  logic [31:0] axis_spd [3];
  logic [2:0]  endstop_q;
  logic [15:0] stop_limit;
  logic [30:0] x_limit;
  logic [30:0] z_limit;

  // Responses still owed by the block, oldest first.
  resp_word_t pending_responses[$];

  int fail_count = 0;
  int responses_seen = 0;
  int cycle_count = 0;
  int hold_off_request = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------

  function automatic logic [7:0] byte_fold(input logic [31:0] w);
    return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
  endfunction

  function automatic logic [7:0] packet_sum(input cmd_word_t w);
    return w.cmd ^ w.axis ^ byte_fold(w.val) ^ byte_fold(w.spd);
  endfunction

  // X and Z sit on their endstop only at zero. Y counts as home at every
  // whole turn, judged on the magnitude of the signed position.
  function automatic logic at_home(input int ax, input logic [31:0] p);
    logic [31:0] mag;
    if (ax == tamch_pkg::AXIS_Y) begin
      mag = p[31] ? (32'd0 - p) : p;
      return (mag % tamch_pkg::Y_STEPS_PER_TURN) == 0;
    end
    return p == 32'd0;
  endfunction

  task automatic reset_state();
    stop_limit = tamch_pkg::STOP_LIMIT_RESET;
    x_limit = tamch_pkg::X_MAX_RESET;
    z_limit = tamch_pkg::Z_MAX_RESET;
    for (int i = 0; i < 3; i++) axis_pos[i] = 32'd0;
    axis_spd[0] = tamch_pkg::X_SPEED_RESET;
    axis_spd[1] = tamch_pkg::Y_SPEED_RESET;
    axis_spd[2] = tamch_pkg::Z_SPEED_RESET;
    endstop_q = 3'b111;
  endtask

  // Runs one accepted command word against the state and returns the
  // response word that the block owes for it.
  function automatic resp_word_t compute_response(input cmd_word_t w);
    resp_word_t r;
    int ax;
    longint target;
    longint lim;
    r = '0;
    if (packet_sum(w) != w.csum) begin
      // A corrupted packet is rejected before the temperature is looked at.
      r.err = tamch_pkg::ERR_CHECKSUM;
    end else if ($signed(w.temp) >= $signed(stop_limit)) begin
      r.err = tamch_pkg::ERR_THERMAL;
      r.act = tamch_pkg::ACT_STOP_ALL;
    end else if (w.cmd >= tamch_pkg::OPC_MOVE_X && w.cmd <= tamch_pkg::OPC_MOVE_Z) begin
      ax = w.cmd - tamch_pkg::OPC_MOVE_X;
      // X and Z targets are checked on the full 33-bit sum, so a huge delta
      // cannot wrap back into range. Y has no limits and wraps.
      target = longint'($signed(axis_pos[ax])) + longint'($signed(w.val));
      lim = (ax == tamch_pkg::AXIS_X) ? longint'(x_limit) : longint'(z_limit);
      if (ax != tamch_pkg::AXIS_Y && (target < 0 || target > lim)) begin
        r.err = tamch_pkg::ERR_RANGE;
      end else begin
        if ($signed(w.spd) > 0) axis_spd[ax] = w.spd;
        axis_pos[ax] = axis_pos[ax] + w.val;
        endstop_q[ax] = at_home(ax, axis_pos[ax]);
        r.act = tamch_pkg::ACT_MOVE;
        r.act_axis = ax[1:0];
        r.arg_a = w.val;
        r.arg_b = axis_spd[ax];
      end
    end else if (w.cmd >= tamch_pkg::OPC_HOME_X && w.cmd <= tamch_pkg::OPC_HOME_Z) begin
      ax = w.cmd - tamch_pkg::OPC_HOME_X;
      axis_pos[ax] = 32'd0;
      endstop_q[ax] = at_home(ax, axis_pos[ax]);
      r.act = tamch_pkg::ACT_HOME;
      r.act_axis = ax[1:0];
    end else begin
      case (w.cmd)
        tamch_pkg::OPC_SET_SPEED: begin
          if (w.axis > 8'd2 || $signed(w.spd) <= 0) r.err = tamch_pkg::ERR_COMMAND;
          else axis_spd[w.axis] = w.spd;
        end
        tamch_pkg::OPC_STATUS, tamch_pkg::OPC_TEMP: begin
        end
        tamch_pkg::OPC_HALT: r.act = tamch_pkg::ACT_STOP_ALL;
        tamch_pkg::OPC_FAN_START: r.act = tamch_pkg::ACT_FAN_ON;
        tamch_pkg::OPC_FAN_HALT: r.act = tamch_pkg::ACT_FAN_OFF;
        tamch_pkg::OPC_FAN_THR: begin
          if ($signed(w.val) <= $signed(w.spd)) begin
            r.err = tamch_pkg::ERR_COMMAND;
          end else begin
            r.act = tamch_pkg::ACT_FAN_THR;
            r.arg_a = w.val;
            r.arg_b = w.spd;
          end
        end
        default: r.err = tamch_pkg::ERR_COMMAND;
      endcase
    end
    r.status = (r.err != tamch_pkg::ERR_NONE);
    r.xpos = axis_pos[0];
    r.ypos = axis_pos[1];
    r.zpos = axis_pos[2];
    r.endstops = endstop_q;
    r.temp = w.temp;
    r.rsum = {7'd0, r.status} ^ {5'd0, r.err} ^ byte_fold(r.xpos) ^ byte_fold(r.ypos) ^
             byte_fold(r.zpos) ^ {5'd0, r.endstops} ^ w.temp[7:0] ^ w.temp[15:8];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Most gaps are zero or short; a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_word_t make_word(input logic [7:0] cmd, input logic [7:0] axis,
                                          input logic [31:0] val, input logic [31:0] spd,
                                          input logic [15:0] temp);
    cmd_word_t w;
    w.cmd = cmd;
    w.axis = axis;
    w.val = val;
    w.spd = spd;
    w.temp = temp;
    w.csum = packet_sum(w);
    return w;
  endfunction

  // Random command word. Most are well-formed commands aimed at the edges of
  // the current state: moves that land on or just past a bound, Y moves onto
  // whole turns, thresholds that are sometimes equal. The rest is raw noise.
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int pick;
    int ax;
    logic [31:0] lim;
    pick = $urandom_range(0, 99);
    w.axis = 8'($urandom_range(0, 3));
    w.val = $urandom;
    w.spd = $urandom;
    if (pick < 35) begin
      ax = $urandom_range(0, 2);
      w.cmd = tamch_pkg::OPC_MOVE_X + 8'(ax);
      lim = (ax == tamch_pkg::AXIS_X) ? {1'b0, x_limit} : {1'b0, z_limit};
      case ($urandom_range(0, 5))
        0, 1: w.val = $urandom_range(0, 1000) - 500;
        2: w.val = lim - axis_pos[ax] + $urandom_range(0, 1);
        3: w.val = 32'd0 - axis_pos[ax] - $urandom_range(0, 1);
        4: w.val = tamch_pkg::Y_STEPS_PER_TURN * ($urandom_range(0, 8) - 4) - axis_pos[ax];
        default: begin
        end
      endcase
      case ($urandom_range(0, 3))
        0, 1: w.spd = 32'd0;
        2: w.spd = $urandom_range(1, 20000);
        default: begin
        end
      endcase
    end else if (pick < 45) begin
      w.cmd = tamch_pkg::OPC_HOME_X + 8'($urandom_range(0, 2));
    end else if (pick < 55) begin
      w.cmd = tamch_pkg::OPC_SET_SPEED;
      if ($urandom_range(0, 7) == 0) w.axis = 8'($urandom);
      if ($urandom_range(0, 1) == 1) w.spd = $urandom_range(0, 30000) - 2;
    end else if (pick < 65) begin
      w.cmd = tamch_pkg::OPC_FAN_THR;
      if ($urandom_range(0, 1) == 1) begin
        w.val = $urandom_range(0, 6000);
        w.spd = $urandom_range(0, 6000);
      end
      if ($urandom_range(0, 5) == 0) w.spd = w.val;
    end else if (pick < 88) begin
      case ($urandom_range(0, 4))
        0: w.cmd = tamch_pkg::OPC_STATUS;
        1: w.cmd = tamch_pkg::OPC_TEMP;
        2: w.cmd = tamch_pkg::OPC_HALT;
        3: w.cmd = tamch_pkg::OPC_FAN_START;
        default: w.cmd = tamch_pkg::OPC_FAN_HALT;
      endcase
    end else begin
      w.cmd = 8'($urandom);
      w.axis = 8'($urandom);
    end
    // Temperature mostly in a normal band, sometimes exactly at or one below
    // the stop limit, sometimes anywhere in the 16-bit range.
    case ($urandom_range(0, 9))
      0: w.temp = stop_limit;
      1: w.temp = stop_limit - 16'd1;
      2: w.temp = 16'($urandom);
      default: w.temp = 16'($urandom_range(0, 6000) - 2500);
    endcase
    w.csum = packet_sum(w);
    if ($urandom_range(0, 9) == 0) w.csum = w.csum ^ 8'($urandom_range(1, 255));
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("mismatch in %s at response %0d: got %h, want %h",
               what, responses_seen, got, want);
  endtask

  // Offers one command word, holds it until the block takes it, then
  // records the response that it owes. Called right after a rising edge.
  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command_code <= w.cmd;
    axis_select <= w.axis;
    value_arg <= w.val;
    speed_arg <= w.spd;
    packet_checksum <= w.csum;
    temperature_cdeg <= w.temp;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_responses.push_back(compute_response(w));
  endtask

  // Stops offering and waits until every owed response is back, then waits on
  // so that a stray extra response would still be caught.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes one register through the APB port and reads it back. Only called
  // when the block is idle.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      tamch_pkg::REG_STOP_LIMIT: stop_limit = data[15:0];
      tamch_pkg::REG_X_MAX: x_limit = data[30:0];
      default: z_limit = data[30:0];
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    mask = (idx == tamch_pkg::REG_STOP_LIMIT) ? 32'h0000_FFFF : 32'h7FFF_FFFF;
    if ((prdata & mask) !== (data & mask))
      report_mismatch("register readback", prdata & mask, data & mask);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  // The receiver stalls in random bursts while idling is on. A hold-off
  // request from a test makes it stall unbroken for the requested length.
  initial begin : response_receiver
    int stall_left;
    int run_left;
    logic stall_next;
    stall_left = 0;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        stall_left = hold_off_request;
        hold_off_request = 0;
      end
      if (stall_left > 0) begin
        stall_next = 1'b1;
        stall_left--;
      end else if (!rx_idle_en || run_left > 0) begin
        stall_next = 1'b0;
        if (run_left > 0) run_left--;
      end else begin
        stall_next = 1'b0;
        run_left = $urandom_range(0, 6);
        stall_left = pick_gap();
      end
      out_stall <= stall_next;
    end
  end

  // Every response word taken by the receiver is matched against the oldest
  // owed response, field by field.
  always @(posedge clk) begin : response_check
    resp_word_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response with nothing owed", 32'd0, 32'd0);
      end else begin
        want = pending_responses.pop_front();
        if (status_flag !== want.status)
          report_mismatch("status_flag", 32'(status_flag), 32'(want.status));
        if (error_code !== want.err)
          report_mismatch("error_code", 32'(error_code), 32'(want.err));
        if (x_position !== want.xpos) report_mismatch("x_position", x_position, want.xpos);
        if (y_position !== want.ypos) report_mismatch("y_position", y_position, want.ypos);
        if (z_position !== want.zpos) report_mismatch("z_position", z_position, want.zpos);
        if (endstop_bits !== want.endstops)
          report_mismatch("endstop_bits", 32'(endstop_bits), 32'(want.endstops));
        if (reported_temp_cdeg !== want.temp)
          report_mismatch("reported_temp_cdeg", 32'(reported_temp_cdeg), 32'(want.temp));
        if (response_checksum !== want.rsum)
          report_mismatch("response_checksum", 32'(response_checksum), 32'(want.rsum));
        if (action_code !== want.act)
          report_mismatch("action_code", 32'(action_code), 32'(want.act));
        if (action_axis !== want.act_axis)
          report_mismatch("action_axis", 32'(action_axis), 32'(want.act_axis));
        if (action_arg_a !== want.arg_a)
          report_mismatch("action_arg_a", action_arg_a, want.arg_a);
        if (action_arg_b !== want.arg_b)
          report_mismatch("action_arg_b", action_arg_b, want.arg_b);
      end
      responses_seen++;
    end
  end

  // A run that hangs ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A bad checksum wins over everything, even a temperature far above the
  // limit. With a good checksum the limit itself already shuts down.
  task automatic test_checksum_and_thermal();
    cmd_word_t w;
    send_word(make_word(tamch_pkg::OPC_STATUS, 8'h00, 32'h0, 32'h0, 16'h0000));
    w = make_word(tamch_pkg::OPC_MOVE_X, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF);
    w.csum = w.csum ^ 8'hFF;
    send_word(w);
    send_word(make_word(tamch_pkg::OPC_MOVE_X, 8'h00, 32'd100, 32'd0,
                        tamch_pkg::STOP_LIMIT_RESET));
    send_word(make_word(tamch_pkg::OPC_STATUS, 8'h00, 32'h0, 32'h0,
                        tamch_pkg::STOP_LIMIT_RESET - 16'd1));
    send_word(make_word(tamch_pkg::OPC_TEMP, 8'h00, 32'h0, 32'h0, 16'h8000));
  endtask

  // Moves onto and past both X bounds, Y across the sign boundary and onto
  // whole turns, and a Z delta whose sum passes the 32-bit signed range.
  task automatic test_moves();
    send_word(make_word(tamch_pkg::OPC_MOVE_X, 8'h00, 32'd200000, 32'd0, 16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_X, 8'h00, 32'd1, 32'd0, 16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_X, 8'h00, -32'sd200001, 32'd0, 16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_X, 8'h00, -32'sd200000, 32'd5000, 16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_Y, 8'h00, 32'h8000_0000, 32'hFFFF_FFFF,
                        16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_Y, 8'h00, 32'h8000_0000, 32'd0, 16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_Y, 8'h00, -32'sd6400, 32'd777, 16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_Z, 8'h00, 32'd120000, 32'h7FFF_FFFF,
                        16'd100));
    send_word(make_word(tamch_pkg::OPC_MOVE_Z, 8'h00, 32'h7FFF_FFFF, 32'd0, 16'd100));
  endtask

  // Homing every axis, then set-speed with a bad axis, a zero speed, the
  // most negative speed and the largest speed.
  task automatic test_home_and_speed();
    send_word(make_word(tamch_pkg::OPC_HOME_X, 8'h00, 32'h0, 32'h0, 16'd0));
    send_word(make_word(tamch_pkg::OPC_HOME_Y, 8'h00, 32'h0, 32'h0, 16'd0));
    send_word(make_word(tamch_pkg::OPC_HOME_Z, 8'h00, 32'h0, 32'h0, 16'd0));
    send_word(make_word(tamch_pkg::OPC_SET_SPEED, 8'd3, 32'h0, 32'd100, 16'd0));
    send_word(make_word(tamch_pkg::OPC_SET_SPEED, 8'd1, 32'h0, 32'd0, 16'd0));
    send_word(make_word(tamch_pkg::OPC_SET_SPEED, 8'd2, 32'h0, 32'h8000_0000, 16'd0));
    send_word(make_word(tamch_pkg::OPC_SET_SPEED, 8'd0, 32'h0, 32'h7FFF_FFFF, 16'd0));
  endtask

  // Fan commands, equal thresholds, the widest thresholds, stop and an
  // unknown command byte.
  task automatic test_fan_and_misc();
    send_word(make_word(tamch_pkg::OPC_FAN_START, 8'h00, 32'h0, 32'h0, 16'd2500));
    send_word(make_word(tamch_pkg::OPC_FAN_HALT, 8'h00, 32'h0, 32'h0, 16'd2500));
    send_word(make_word(tamch_pkg::OPC_FAN_THR, 8'h00, 32'd100, 32'd100, 16'd2500));
    send_word(make_word(tamch_pkg::OPC_FAN_THR, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000,
                        16'd2500));
    send_word(make_word(tamch_pkg::OPC_HALT, 8'h00, 32'h0, 32'h0, 16'd2500));
    send_word(make_word(8'hFF, 8'hFF, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 16'd2500));
  endtask

  // Register phases: the extremes of each register, a tight setting, then
  // the reset values again. Writes happen only once the block is idle.
  task automatic test_register_settings();
    logic [15:0] stops [4];
    logic [30:0] xmaxes [4];
    logic [30:0] zmaxes [4];
    int counts [4];
    stops = '{16'h7FFF, 16'h8000, 16'd1500, tamch_pkg::STOP_LIMIT_RESET};
    xmaxes = '{31'h7FFF_FFFF, 31'd0, 31'd3000, tamch_pkg::X_MAX_RESET};
    zmaxes = '{31'd0, 31'h7FFF_FFFF, 31'd5000, tamch_pkg::Z_MAX_RESET};
    counts = '{70, 40, 70, 70};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_register(tamch_pkg::REG_STOP_LIMIT, {{16{stops[p][15]}}, stops[p]});
      write_register(tamch_pkg::REG_X_MAX, {1'b0, xmaxes[p]});
      write_register(tamch_pkg::REG_Z_MAX, {1'b0, zmaxes[p]});
      @(posedge clk);
      repeat (counts[p]) send_word(random_word());
    end
  endtask

  // The receiver holds off for a long stretch while the sender offers words
  // back to back, so the block fills up and stalls its input.
  task automatic test_backpressure();
    wait_idle();
    tx_idle_en = 1'b0;
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (60) send_word(random_word());
    tx_idle_en = 1'b1;
  endtask

  // Long random run in blocks; the first block has no idling on either
  // side, later blocks switch idling on and off at random.
  task automatic test_random_traffic();
    for (int blk = 0; blk < 8; blk++) begin
      tx_idle_en = (blk != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (blk != 0) && ($urandom_range(0, 3) != 0);
      repeat (100) send_word(random_word());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    command_code <= '0;
    axis_select <= '0;
    value_arg <= '0;
    speed_arg <= '0;
    packet_checksum <= '0;
    temperature_cdeg <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reset_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_checksum_and_thermal();
    test_moves();
    test_home_and_speed();
    test_fan_and_misc();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
